// ===== sv/jvsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jvsp_pkg
// Shared types, codes and constants for the vocabulary stream parser.
// ----------------------------------------------------------------------------
package jvsp_pkg;

  localparam int ENTRY_LIMIT_MAX_DEF = 1048576;
  localparam int TEXT_LIMIT_MAX_DEF  = 1024;

  // configuration port
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 21;
  localparam int MAX_ENTRIES_W = 21;
  localparam int MAX_TEXT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEXT    = 1'd1;

  localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 21'd32768;
  localparam logic [MAX_TEXT_W-1:0]    MAX_TEXT_RST    = 11'd256;

  // result fields
  localparam int KIND_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int ID_W    = 32;
  localparam int INDEX_W = 20;

  localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [ID_W-1:0] ID_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [ID_W-1:0] MAG_CAP    = 32'h8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [BYTE_W-1:0]       text_byte;
    logic signed [ID_W-1:0]  token_id;
    logic [INDEX_W-1:0]      entry_index;
  } result_t;

  // all results caused by one input byte (one to three)
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     rec;
  } bundle_t;

  function automatic result_t mk_text(input logic [BYTE_W-1:0] b,
                                      input logic [INDEX_W-1:0] idx);
    result_t r;
    r.kind        = KIND_TEXT;
    r.text_byte   = b;
    r.token_id    = '0;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic result_t mk_entry(input logic [ID_W-1:0] acc,
                                       input logic neg,
                                       input logic [INDEX_W-1:0] idx);
    result_t r;
    r.kind        = KIND_ENTRY;
    r.text_byte   = '0;
    if (neg) begin
      r.token_id = ID_W'(32'd0 - acc);
    end else begin
      r.token_id = acc[ID_W-1] ? ID_POS_SAT : acc;
    end
    r.entry_index = idx;
    return r;
  endfunction

  function automatic result_t mk_finish();
    result_t r;
    r = '0;
    r.kind = KIND_FINISH;
    return r;
  endfunction

endpackage

// ===== sv/jvsp_parser.sv =====
// ----------------------------------------------------------------------------
// jvsp_parser
// Parse state, limit registers and the per-byte result bundle.
// ----------------------------------------------------------------------------
module jvsp_parser
  import jvsp_pkg::*;
#(
  parameter int ENTRY_LIMIT_MAX = ENTRY_LIMIT_MAX_DEF,
  parameter int TEXT_LIMIT_MAX  = TEXT_LIMIT_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_accept,
  input  logic [BYTE_W-1:0]     in_byte_in,
  input  logic                  in_first_byte,
  input  logic                  in_final_byte,
  output logic                  push_valid,
  output bundle_t               push_bundle
);

  localparam int ECNT_W = $clog2(ENTRY_LIMIT_MAX + 1);
  localparam int ELIM_W = (ECNT_W > MAX_ENTRIES_W) ? ECNT_W : MAX_ENTRIES_W;
  localparam int TCNT_W = $clog2(TEXT_LIMIT_MAX);
  localparam int TLW0   = $clog2(TEXT_LIMIT_MAX + 1);
  localparam int TLIM_W = (TLW0 > MAX_TEXT_W) ? TLW0 : MAX_TEXT_W;

  localparam logic [ELIM_W-1:0] ENT_CAP = ELIM_W'(ENTRY_LIMIT_MAX);
  localparam logic [TLIM_W-1:0] TXT_CAP = TLIM_W'(TEXT_LIMIT_MAX);

  localparam logic [2:0] M_SEEK_QUOTE = 3'd0;
  localparam logic [2:0] M_KEY        = 3'd1;
  localparam logic [2:0] M_SEEK_COLON = 3'd2;
  localparam logic [2:0] M_SPACE      = 3'd3;
  localparam logic [2:0] M_SIGN       = 3'd4;
  localparam logic [2:0] M_DIGITS     = 3'd5;
  localparam logic [2:0] M_SEEK_SEP   = 3'd6;
  localparam logic [2:0] M_DONE       = 3'd7;

  logic [MAX_ENTRIES_W-1:0] max_entries_r;
  logic [MAX_TEXT_W-1:0]    max_text_r;

  logic [2:0]        mode_r, mode_nxt;
  logic              esc_r, esc_nxt;
  logic [TCNT_W-1:0] tc_r, tc_nxt;
  logic [ECNT_W-1:0] ec_r, ec_nxt;
  logic [ID_W-1:0]   acc_r, acc_nxt;
  logic              neg_r, neg_nxt;

  logic [ELIM_W-1:0] ent_lim;
  logic [TLIM_W-1:0] txt_lim;
  logic [TLIM_W-1:0] keep;

  result_t           res [3];
  logic [1:0]        n;
  logic              txt_a_en, txt_b_en, end_num;
  logic [BYTE_W-1:0] txt_a, txt_b;
  logic [ID_W+2:0]   acc_x10;
  logic [BYTE_W-1:0] b;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
      max_text_r    <= MAX_TEXT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_ENTRIES: max_entries_r <= cfg_data[MAX_ENTRIES_W-1:0];
        CFG_MAX_TEXT:    max_text_r    <= cfg_data[MAX_TEXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ent_lim = (ELIM_W'(max_entries_r) > ENT_CAP) ? ENT_CAP : ELIM_W'(max_entries_r);
    txt_lim = (TLIM_W'(max_text_r) > TXT_CAP) ? TXT_CAP : TLIM_W'(max_text_r);
    keep    = (txt_lim == '0) ? '0 : txt_lim - 1'b1;
  end

  always_comb begin
    b        = in_byte_in;
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    tc_nxt   = tc_r;
    ec_nxt   = ec_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    res      = '{default: '0};
    n        = 2'd0;
    txt_a_en = 1'b0;
    txt_b_en = 1'b0;
    txt_a    = '0;
    txt_b    = '0;
    end_num  = 1'b0;
    acc_x10  = (ID_W+3)'(acc_r) * (ID_W+3)'(10);

    if (in_first_byte) begin
      mode_nxt = M_SEEK_QUOTE;
      esc_nxt  = 1'b0;
      tc_nxt   = '0;
      ec_nxt   = '0;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      acc_x10  = '0;
    end

    if (mode_nxt == M_DONE) begin
      // idle until the next buffer starts
    end else if (ELIM_W'(ec_nxt) >= ent_lim) begin
      res[0]   = mk_finish();
      n        = 2'd1;
      mode_nxt = M_DONE;
    end else begin
      case (mode_nxt)
        M_SEEK_QUOTE: begin
          if (b == CH_QUOTE) begin
            mode_nxt = M_KEY;
            tc_nxt   = '0;
            esc_nxt  = 1'b0;
          end
        end
        M_KEY: begin
          if (esc_nxt) begin
            esc_nxt  = 1'b0;
            txt_a_en = 1'b1;
            if (b == CH_QUOTE) begin
              // backslash before the closing quote: keep it, key ends
              txt_a    = CH_BSLASH;
              mode_nxt = M_SEEK_COLON;
            end else if (b == CH_N) begin
              txt_a = CH_LF;
            end else if (b == CH_T) begin
              txt_a = CH_TAB;
            end else if (b == CH_R) begin
              txt_a = CH_CR;
            end else if (b == CH_BSLASH) begin
              txt_a = CH_BSLASH;
            end else begin
              // unknown escape: keep the backslash and the byte
              txt_a    = CH_BSLASH;
              txt_b_en = 1'b1;
              txt_b    = b;
            end
          end else if (b == CH_QUOTE) begin
            mode_nxt = M_SEEK_COLON;
          end else if (b == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else begin
            txt_a_en = 1'b1;
            txt_a    = b;
          end
        end
        M_SEEK_COLON: begin
          if (b == CH_COLON) begin
            mode_nxt = M_SPACE;
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            acc_x10  = '0;
          end
        end
        M_SPACE, M_SIGN, M_DIGITS: begin
          if (mode_nxt == M_SPACE && (b inside {CH_SPACE, [CH_TAB:CH_CR]})) begin
            // skip whitespace
          end else if (mode_nxt == M_SPACE && (b == CH_PLUS || b == CH_MINUS)) begin
            neg_nxt  = (b == CH_MINUS);
            mode_nxt = M_SIGN;
          end else if (b inside {[CH_0:CH_9]}) begin
            acc_x10  = acc_x10 + (ID_W+3)'(b - CH_0);
            acc_nxt  = (acc_x10 > (ID_W+3)'(MAG_CAP)) ? MAG_CAP : acc_x10[ID_W-1:0];
            mode_nxt = M_DIGITS;
          end else begin
            end_num = 1'b1;
          end
        end
        default: begin
          if (b == CH_RBRACE) begin
            res[n]   = mk_finish();
            n        = n + 2'd1;
            mode_nxt = M_DONE;
          end else if (b == CH_COMMA) begin
            mode_nxt = M_SEEK_QUOTE;
          end
        end
      endcase

      if (txt_a_en && TLIM_W'(tc_nxt) < keep) begin
        res[n] = mk_text(txt_a, INDEX_W'(ec_nxt));
        n      = n + 2'd1;
        tc_nxt = tc_nxt + 1'b1;
      end
      if (txt_b_en && TLIM_W'(tc_nxt) < keep) begin
        res[n] = mk_text(txt_b, INDEX_W'(ec_nxt));
        n      = n + 2'd1;
        tc_nxt = tc_nxt + 1'b1;
      end

      if (end_num) begin
        res[n] = mk_entry(acc_nxt, neg_nxt, INDEX_W'(ec_nxt));
        n      = n + 2'd1;
        ec_nxt = ec_nxt + 1'b1;
        if (ELIM_W'(ec_nxt) >= ent_lim || b == CH_RBRACE) begin
          res[n]   = mk_finish();
          n        = n + 2'd1;
          mode_nxt = M_DONE;
        end else begin
          mode_nxt = (b == CH_COMMA) ? M_SEEK_QUOTE : M_SEEK_SEP;
        end
      end

      // buffer end: flush a pending number, then close
      if (in_final_byte && mode_nxt != M_DONE) begin
        if (mode_nxt inside {M_SPACE, M_SIGN, M_DIGITS}) begin
          res[n] = mk_entry(acc_nxt, neg_nxt, INDEX_W'(ec_nxt));
          n      = n + 2'd1;
          ec_nxt = ec_nxt + 1'b1;
        end
        res[n]   = mk_finish();
        n        = n + 2'd1;
        mode_nxt = M_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_SEEK_QUOTE;
      esc_r  <= 1'b0;
      tc_r   <= '0;
      ec_r   <= '0;
      acc_r  <= '0;
      neg_r  <= 1'b0;
    end else if (in_accept) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      tc_r   <= tc_nxt;
      ec_r   <= ec_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
    end
  end

  always_comb begin
    push_valid         = in_accept && (n != 2'd0);
    push_bundle.count  = n;
    push_bundle.rec[0] = res[0];
    push_bundle.rec[1] = res[1];
    push_bundle.rec[2] = res[2];
  end

endmodule

// ===== sv/jvsp_result_queue.sv =====
// ----------------------------------------------------------------------------
// jvsp_result_queue
// Queue of per-byte result bundles, unpacked one result per beat.
// ----------------------------------------------------------------------------
module jvsp_result_queue
  import jvsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  input  bundle_t                   push_bundle,
  output logic                      full,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [KIND_W-1:0]         out_kind,
  output logic [BYTE_W-1:0]         out_text_byte,
  output logic signed [ID_W-1:0]    out_token_id,
  output logic [INDEX_W-1:0]        out_entry_index,
  output logic                      out_last_of_run
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t           q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [1:0]        slot_r;

  bundle_t head;
  result_t cur;
  logic    last, beat, pop;

  always_comb begin
    head      = q_mem[head_r];
    cur       = head.rec[slot_r];
    out_valid = (count_r != '0);
    full      = (count_r == CNT_W'(QUEUE_DEPTH));
    last      = (slot_r == head.count - 2'd1);
    beat      = out_valid && !out_stall;
    pop       = beat && last;

    out_kind        = cur.kind;
    out_text_byte   = cur.text_byte;
    out_token_id    = cur.token_id;
    out_entry_index = cur.entry_index;
    out_last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_mem[tail_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      slot_r  <= 2'd0;
    end else begin
      if (push_valid) begin
        tail_r <= (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        slot_r <= 2'd0;
      end else if (beat) begin
        slot_r <= slot_r + 2'd1;
      end
      count_r <= count_r + CNT_W'(push_valid) - CNT_W'(pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("bundle pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_slot_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.count != 2'd0 && slot_r < head.count))
    else $error("result slot outside head bundle");

  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> slot_r == 2'd0)
    else $error("slot index left over on empty queue");

endmodule

// ===== sv/json_vocab_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// json_vocab_stream_parser_core
// Byte-stream parser for a JSON object of "key": integer pairs.
//
// Input channel (in_*): one raw byte per beat, with first/final buffer flags.
// Output channel (out_*): key text bytes, entry-complete records and a
// parse-finished record, one per beat; out_last_of_run marks the last
// result caused by an input byte.
// Config port (cfg_*): index 0 max_entries, index 1 max_text; write only
// while the block is idle.
// Throughput: one input byte per cycle while in_stall is low. Each byte's
// results are parsed in the cycle it is taken and land in a four-bundle
// result queue, which registers them before they reach out_*. Each result
// takes its own output beat, so the queue sets the sustained rate when
// bytes giving two or three results cluster or the receiver stalls.
// in_stall rises only when the queue holds four bundles.
// Reset: parse state clears, limits return to 32768 and 256, queue empties.
// ----------------------------------------------------------------------------
module json_vocab_stream_parser_core
  import jvsp_pkg::*;
#(
  parameter int ENTRY_LIMIT_MAX = ENTRY_LIMIT_MAX_DEF,
  parameter int TEXT_LIMIT_MAX  = TEXT_LIMIT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_byte_in,
  input  logic                   in_first_byte,
  input  logic                   in_final_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [BYTE_W-1:0]      out_text_byte,
  output logic signed [ID_W-1:0] out_token_id,
  output logic [INDEX_W-1:0]     out_entry_index,
  output logic                   out_last_of_run
);

  logic    in_accept;
  logic    push_valid;
  bundle_t push_bundle;
  logic    q_full;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  jvsp_parser #(
    .ENTRY_LIMIT_MAX (ENTRY_LIMIT_MAX),
    .TEXT_LIMIT_MAX  (TEXT_LIMIT_MAX)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .in_byte_in    (in_byte_in),
    .in_first_byte (in_first_byte),
    .in_final_byte (in_final_byte),
    .push_valid    (push_valid),
    .push_bundle   (push_bundle)
  );

  jvsp_result_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_valid      (push_valid),
    .push_bundle     (push_bundle),
    .full            (q_full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_text_byte   (out_text_byte),
    .out_token_id    (out_token_id),
    .out_entry_index (out_entry_index),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== tb/jvsp_result_checker.sv =====
// ----------------------------------------------------------------------------
// jvsp_result_checker
// Watches the input, output and config ports of the vocabulary stream
// parser. Predicts the result beats caused by each accepted input byte and
// compares every accepted output beat, field by field, with the oldest
// prediction. Reports the number of failures and of beats still owed.
// ----------------------------------------------------------------------------
module jvsp_result_checker
  import jvsp_pkg::*;
#(
  parameter int ENTRY_LIMIT_MAX = ENTRY_LIMIT_MAX_DEF,
  parameter int TEXT_LIMIT_MAX  = TEXT_LIMIT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_byte_in,
  input  logic                   in_first_byte,
  input  logic                   in_final_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [KIND_W-1:0]      out_kind,
  input  logic [BYTE_W-1:0]      out_text_byte,
  input  logic signed [ID_W-1:0] out_token_id,
  input  logic [INDEX_W-1:0]     out_entry_index,
  input  logic                   out_last_of_run,
  output int                     fail_count,
  output int                     beats_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef enum logic [2:0] {
    SEEK_QUOTE,
    IN_KEY,
    SEEK_COLON,
    SKIP_SPACE,
    AFTER_SIGN,
    IN_DIGITS,
    SEEK_SEP,
    PARSE_DONE
  } parse_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  text_byte;
    logic [ID_W-1:0]    token_id;
    logic [INDEX_W-1:0] entry_index;
    logic               last_of_run;
  } parse_beat_t;

  parse_mode_t              mode;
  logic                     esc_pending;
  int unsigned              key_len;
  int unsigned              entries_done;
  logic [ID_W-1:0]          id_mag;
  logic                     id_neg;
  logic [MAX_ENTRIES_W-1:0] max_entries_q;
  logic [MAX_TEXT_W-1:0]    max_text_q;

  parse_beat_t awaited_beats[$];
  parse_beat_t byte_beats[$];

  function automatic void clear_parse();
    mode         = SEEK_QUOTE;
    esc_pending  = 1'b0;
    key_len      = 0;
    entries_done = 0;
    id_mag       = '0;
    id_neg       = 1'b0;
  endfunction

  function automatic int unsigned entry_cap();
    return (max_entries_q > ENTRY_LIMIT_MAX) ? ENTRY_LIMIT_MAX : max_entries_q;
  endfunction

  function automatic void push_beat(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] b,
                                    input logic [ID_W-1:0] id,
                                    input int unsigned idx);
    parse_beat_t r;
    r.kind        = kind;
    r.text_byte   = b;
    r.token_id    = id;
    r.entry_index = INDEX_W'(idx);
    r.last_of_run = 1'b0;
    byte_beats.push_back(r);
  endfunction

  function automatic void push_key_byte(input logic [7:0] b);
    int unsigned t;
    int unsigned keep;
    t    = (max_text_q > TEXT_LIMIT_MAX) ? TEXT_LIMIT_MAX : max_text_q;
    keep = (t == 0) ? 0 : t - 1;
    if (key_len < keep) begin
      key_len++;
      push_beat(KIND_TEXT, b, '0, entries_done);
    end
  endfunction

  function automatic void push_entry();
    logic [ID_W-1:0] id;
    if (id_neg) begin
      id = 32'd0 - id_mag;
    end else begin
      id = (id_mag >= MAG_CAP) ? ID_POS_SAT : id_mag;
    end
    push_beat(KIND_ENTRY, '0, id, entries_done);
    entries_done++;
  endfunction

  function automatic void push_finish();
    mode = PARSE_DONE;
    push_beat(KIND_FINISH, '0, '0, 0);
  endfunction

  function automatic void close_number(input logic [7:0] b);
    push_entry();
    if (entries_done >= entry_cap() || b == CH_RBRACE) begin
      push_finish();
    end else begin
      mode = (b == CH_COMMA) ? SEEK_QUOTE : SEEK_SEP;
    end
  endfunction

  // magnitude saturates at 2^31 so that a minus sign still reaches the minimum
  function automatic void accumulate_digit(input logic [7:0] b);
    logic [63:0] v;
    v      = {32'd0, id_mag} * 64'd10 + 64'(b) - 64'(CH_0);
    id_mag = (v > 64'(MAG_CAP)) ? MAG_CAP : v[31:0];
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic first,
                                     input logic fin);
    logic        is_digit;
    parse_beat_t r;
    byte_beats.delete();
    is_digit = (b >= CH_0) && (b <= CH_9);
    if (first) begin
      clear_parse();
    end
    if (mode == PARSE_DONE) begin
      return;
    end
    if (entries_done >= entry_cap()) begin
      push_finish();
    end else begin
      case (mode)
        SEEK_QUOTE: begin
          if (b == CH_QUOTE) begin
            mode        = IN_KEY;
            key_len     = 0;
            esc_pending = 1'b0;
          end
        end
        IN_KEY: begin
          if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == CH_QUOTE) begin
              push_key_byte(CH_BSLASH);
              mode = SEEK_COLON;
            end else if (b == CH_N) begin
              push_key_byte(CH_LF);
            end else if (b == CH_T) begin
              push_key_byte(CH_TAB);
            end else if (b == CH_R) begin
              push_key_byte(CH_CR);
            end else if (b == CH_BSLASH) begin
              push_key_byte(CH_BSLASH);
            end else begin
              push_key_byte(CH_BSLASH);
              push_key_byte(b);
            end
          end else if (b == CH_QUOTE) begin
            mode = SEEK_COLON;
          end else if (b == CH_BSLASH) begin
            esc_pending = 1'b1;
          end else begin
            push_key_byte(b);
          end
        end
        SEEK_COLON: begin
          if (b == CH_COLON) begin
            mode   = SKIP_SPACE;
            id_mag = '0;
            id_neg = 1'b0;
          end
        end
        SKIP_SPACE: begin
          if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
              b == CH_FF || b == CH_CR) begin
            // skipped
          end else if (b == CH_PLUS || b == CH_MINUS) begin
            id_neg = (b == CH_MINUS);
            mode   = AFTER_SIGN;
          end else if (is_digit) begin
            accumulate_digit(b);
            mode = IN_DIGITS;
          end else begin
            close_number(b);
          end
        end
        AFTER_SIGN, IN_DIGITS: begin
          if (is_digit) begin
            accumulate_digit(b);
            mode = IN_DIGITS;
          end else begin
            close_number(b);
          end
        end
        default: begin
          if (b == CH_RBRACE) begin
            push_finish();
          end else if (b == CH_COMMA) begin
            mode = SEEK_QUOTE;
          end
        end
      endcase
      if (fin && mode != PARSE_DONE) begin
        if (mode == SKIP_SPACE || mode == AFTER_SIGN || mode == IN_DIGITS) begin
          push_entry();
        end
        push_finish();
      end
    end
    while (byte_beats.size() > 0) begin
      r = byte_beats.pop_front();
      r.last_of_run = (byte_beats.size() == 0);
      awaited_beats.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    parse_beat_t want;
    if (!rst_n) begin
      max_entries_q = MAX_ENTRIES_RST;
      max_text_q    = MAX_TEXT_RST;
      clear_parse();
      awaited_beats.delete();
    end else begin
      // a beat leaving now was caused by a byte taken at an earlier edge
      if (out_valid && !out_stall) begin
        if (awaited_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d index %0h", out_kind, out_entry_index);
          fail_count++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("text_byte", want.text_byte, out_text_byte);
          check_field("token_id", want.token_id, out_token_id);
          check_field("entry_index", want.entry_index, out_entry_index);
          check_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MAX_ENTRIES) begin
          max_entries_q = cfg_data[MAX_ENTRIES_W-1:0];
        end else if (cfg_index == CFG_MAX_TEXT) begin
          max_text_q = cfg_data[MAX_TEXT_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_byte_in, in_first_byte, in_final_byte);
      end
    end
    beats_owed = awaited_beats.size();
  end

endmodule

// ===== tb/json_vocab_stream_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// json_vocab_stream_parser_core_test
// Drives byte buffers of key/integer objects into the parser: a directed
// pass over escapes, signs, empty ids and limits, then random well-formed,
// truncated and noisy buffers under several limit settings, with bursty
// input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module json_vocab_stream_parser_core_test;
  import jvsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int QUIET_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_PHASES   = 6;

  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_A      = 8'h61;

  localparam logic [CFG_DATA_W-1:0] PH_ENTRIES [NUM_PHASES] =
    '{21'h1FFFFF, 21'd1, 21'd0, 21'd3, 21'd1048576, 21'd32768};
  localparam logic [CFG_DATA_W-1:0] PH_TEXT [NUM_PHASES] =
    '{21'd2047, 21'd1, 21'd0, 21'd3, 21'd1024, 21'd2};
  localparam int PH_BYTES [NUM_PHASES] = '{40, 15, 5, 20, 20, 20};

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_byte_in;
  logic                   in_first_byte;
  logic                   in_final_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [KIND_W-1:0]      out_kind;
  logic [BYTE_W-1:0]      out_text_byte;
  logic signed [ID_W-1:0] out_token_id;
  logic [INDEX_W-1:0]     out_entry_index;
  logic                   out_last_of_run;

  int   fail_count;
  int   beats_owed;
  int   cycle_count = 0;
  int   burst_left  = 0;
  int   bytes_sent  = 0;
  bit   hold_request = 1'b0;
  logic [7:0] buf_bytes[$];

  json_vocab_stream_parser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_first_byte   (in_first_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_text_byte   (out_text_byte),
    .out_token_id    (out_token_id),
    .out_entry_index (out_entry_index),
    .out_last_of_run (out_last_of_run)
  );

  jvsp_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_first_byte   (in_first_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_text_byte   (out_text_byte),
    .out_token_id    (out_token_id),
    .out_entry_index (out_entry_index),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .beats_owed      (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("json_vocab_stream_parser_core_test: FAIL");
      $finish;
    end
  end

  function automatic bit one_in(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // ---- buffer building ----

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      buf_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void push_ws();
    case ($urandom_range(0, 5))
      0: buf_bytes.push_back(CH_SPACE);
      1: buf_bytes.push_back(CH_TAB);
      2: buf_bytes.push_back(CH_LF);
      3: buf_bytes.push_back(CH_VT);
      4: buf_bytes.push_back(CH_FF);
      default: buf_bytes.push_back(CH_CR);
    endcase
  endfunction

  function automatic void push_key();
    int n_key;
    int pick;
    n_key = one_in(6) ? $urandom_range(7, 12) : $urandom_range(0, 5);
    buf_bytes.push_back(CH_QUOTE);
    for (int i = 0; i < n_key; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        buf_bytes.push_back(8'(CH_A + $urandom_range(0, 25)));
      end else if (pick < 16) begin
        buf_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        buf_bytes.push_back(CH_BSLASH);
        case ($urandom_range(0, 4))
          0: buf_bytes.push_back(CH_N);
          1: buf_bytes.push_back(CH_T);
          2: buf_bytes.push_back(CH_R);
          3: buf_bytes.push_back(CH_BSLASH);
          default: buf_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    // backslash right before the closing quote ends the key
    if (one_in(12)) begin
      buf_bytes.push_back(CH_BSLASH);
    end
    buf_bytes.push_back(CH_QUOTE);
  endfunction

  function automatic void push_number();
    int n_dig;
    int pick;
    case ($urandom_range(0, 3))
      0: buf_bytes.push_back(CH_PLUS);
      1: buf_bytes.push_back(CH_MINUS);
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      n_dig = 0;
    end else if (pick < 4) begin
      n_dig = $urandom_range(10, 12);
    end else if (pick == 4) begin
      n_dig = 0;
      push_str(one_in(2) ? "2147483647" : "2147483648");
    end else begin
      n_dig = $urandom_range(1, 4);
    end
    for (int i = 0; i < n_dig; i++) begin
      buf_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void build_object();
    int n_entries;
    int cut;
    if (one_in(4)) push_ws();
    buf_bytes.push_back(CH_LBRACE);
    n_entries = $urandom_range(1, 4);
    for (int k = 0; k < n_entries; k++) begin
      if (one_in(3)) push_ws();
      push_key();
      if (one_in(3)) push_ws();
      buf_bytes.push_back(CH_COLON);
      if (one_in(2)) push_ws();
      if (one_in(4)) push_ws();
      push_number();
      if (one_in(5)) begin
        push_ws();
      end else if (one_in(8)) begin
        buf_bytes.push_back(8'(CH_A + $urandom_range(0, 25)));
      end
      buf_bytes.push_back((k == n_entries - 1) ? CH_RBRACE : CH_COMMA);
    end
    if (one_in(5)) begin
      repeat ($urandom_range(1, 3)) buf_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // buffer cut short at a random point, possibly mid-key or mid-number
    if (one_in(5)) begin
      cut = $urandom_range(1, buf_bytes.size());
      while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12)) begin
      if (one_in(2)) begin
        buf_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 7))
          0: buf_bytes.push_back(CH_QUOTE);
          1: buf_bytes.push_back(CH_COLON);
          2: buf_bytes.push_back(CH_COMMA);
          3: buf_bytes.push_back(CH_RBRACE);
          4: buf_bytes.push_back(CH_BSLASH);
          5: buf_bytes.push_back(CH_MINUS);
          6: buf_bytes.push_back(CH_SPACE);
          default: buf_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
        endcase
      end
    end
  endfunction

  // ---- driving ----

  task automatic send_byte(input logic [7:0] b, input logic first, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = one_in(3) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = one_in(5) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_byte_in    <= b;
    in_first_byte <= first;
    in_final_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_buffer(input logic first, input logic fin);
    for (int i = 0; i < buf_bytes.size(); i++) begin
      send_byte(buf_bytes[i], first && i == 0, fin && i == buf_bytes.size() - 1);
    end
  endtask

  // idle until nothing is owed and the output has been quiet for a while
  task automatic wait_quiet();
    int quiet;
    in_valid <= 1'b0;
    burst_left = 0;
    quiet = 0;
    while (quiet < QUIET_CYCLES) begin
      @(posedge clk);
      quiet = (beats_owed == 0 && !out_valid) ? quiet + 1 : 0;
    end
  endtask

  task automatic write_limits(input logic [CFG_DATA_W-1:0] entries,
                              input logic [CFG_DATA_W-1:0] text);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_ENTRIES;
    cfg_data  <= entries;
    @(posedge clk);
    cfg_index <= CFG_MAX_TEXT;
    cfg_data  <= text;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: segments of differing stall density, plus one long hold-off
  initial begin : receiver
    int seg;
    int style;
    int k;
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        seg   = $urandom_range(16, 80);
        style = $urandom_range(0, 3);
        for (k = 0; k < seg && !(hold_request && !hold_done); k++) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= one_in(2);
            2: out_stall <= one_in(4);
            default: out_stall <= (k % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int   start;
    logic first;
    logic fin;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_MAX_ENTRIES;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_byte_in    <= '0;
    in_first_byte <= 1'b0;
    in_final_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // escapes, odd escape, extreme bytes, backslash-quote, VT, sign,
    // empty id, close brace, then a byte after the parse has finished
    buf_bytes.delete();
    push_str("\"\\n\\t\\r\\\\\\q");
    buf_bytes.push_back(8'h00);
    buf_bytes.push_back(8'hFF);
    push_str("\\\":");
    buf_bytes.push_back(CH_VT);
    push_str("-9,\"\":}x");
    send_buffer(1'b1, 1'b1);
    wait_quiet();

    // entry limit dropped to the count while a parse is open
    buf_bytes.delete();
    push_str("\"\":1,");
    send_buffer(1'b1, 1'b0);
    wait_quiet();
    write_limits(21'd1, 21'd256);
    buf_bytes.delete();
    buf_bytes.push_back(CH_QUOTE);
    send_buffer(1'b0, 1'b0);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limits(PH_ENTRIES[p], PH_TEXT[p]);
      if (p == 0) hold_request = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < PH_BYTES[p]) begin
        buf_bytes.delete();
        if (one_in(5)) begin
          build_noise();
        end else begin
          build_object();
        end
        first = !one_in(10);
        fin   = !one_in(7);
        send_buffer(first, fin);
      end
      wait_quiet();
    end

    if (beats_owed != 0) begin
      $error("%0d result beats never arrived", beats_owed);
    end
    if (fail_count == 0 && beats_owed == 0) begin
      $display("json_vocab_stream_parser_core_test: PASS");
    end else begin
      $display("json_vocab_stream_parser_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== json_vocab_stream_parser_core.f =====
sv/jvsp_pkg.sv
sv/jvsp_parser.sv
sv/jvsp_result_queue.sv
sv/json_vocab_stream_parser_core.sv
tb/jvsp_result_checker.sv
tb/json_vocab_stream_parser_core_test.sv
